[hdl/gsb_pkg.sv]
// Shared types and constants of the softened-gravity body integrator.
package gsb_pkg;

  localparam int unsigned WORD_W = 32;

  // Operation codes carried on in_tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ACCUM = 2'd1,
    OP_INTEG = 2'd2,
    OP_CLEAR = 2'd3
  } gsb_op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_GRAV = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_SOFT = 2'd2;
  localparam logic [1:0] REG_BIAS = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_R3,
    S_DEN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ACC,
    S_VEL,
    S_POS,
    S_DONE
  } gsb_state_t;

  // Control into the root/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } gsb_rd_ctl_t;

  // Status out of the root/divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } gsb_rd_sts_t;

endpackage

[hdl/gsb_mul.sv]
// Shared signed 33x33 multiplier with a registered product.
module gsb_mul import gsb_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);

  // register every product
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

[hdl/gsb_rootdiv.sv]
// Bit-serial restoring unit: 64-bit integer square root or 64/64 division, one bit a cycle.
module gsb_rootdiv import gsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  gsb_rd_ctl_t ctl,
  input  logic [63:0] init_rem,
  input  logic [63:0] init_sh,
  input  logic [63:0] divisor,
  output gsb_rd_sts_t sts,
  output logic [31:0] result
);

  logic [63:0] rem_r;
  logic [63:0] sh_r;
  logic [31:0] res_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic        div_r;
  logic [64:0] opa;
  logic [64:0] opb;
  logic [65:0] diff;
  logic        ge;

  // shift in the next radicand pair or dividend bit and trial-subtract
  always_comb begin
    if (div_r) begin
      opa = {rem_r, sh_r[63]};
      opb = {1'b0, divisor};
    end else begin
      opa = {rem_r[62:0], sh_r[63:62]};
      opb = {31'b0, res_r, 2'b01};
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[65];
  end

  // control: run 32 steps after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder, operand shift line and result bits
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= init_rem;
      sh_r  <= init_sh;
      res_r <= '0;
      div_r <= ctl.is_div;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : opa[63:0];
      sh_r  <= div_r ? {sh_r[62:0], 1'b0} : {sh_r[61:0], 2'b00};
      res_r <= {res_r[30:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = res_r;

endmodule

[hdl/softened_gravity_body_integrator.sv]
// Top level: one body's state, sequencer and datapath around the shared units.
//
//  channel  | direction | payload
//  in_      | input     | tuser: operation; tdata: x, y, z, vx, vy, vz, other_mass
//  out_     | output    | tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
//  cfg_     | input     | write of grav_const, time_step, soft_sq, denom_bias
//
// Load and clear act at acceptance. An accumulate takes a square root and
// a division (skipped when the force saturates) in the bit-serial unit;
// the rest are passes through the shared multiplier, one product a cycle.
// Reset is synchronous and active low; it zeroes the state and sets the
// registers to their defaults. in_tready is low while an item is in work;
// a result waiting on out_tready holds the block at its last step.
module softened_gravity_body_integrator import gsb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,  // x, y, z, vx, vy, vz, other_mass (lowest first)
  input  logic [1:0]   in_tuser,  // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata, // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (lowest first)
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [63:0] GRAV64 = 64'd1 << FRAC_BITS;
  localparam logic [63:0] STEP64 = (64'd655 << FRAC_BITS) >> 16;
  localparam logic [63:0] SOFT64 = 64'd1 << (FRAC_BITS - 4);

  gsb_state_t state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt, prev;
  logic [31:0] grav_r, step_r, soft_r, bias_r;
  logic [31:0] pos_r [3];
  logic [31:0] vel_r [3];
  logic [31:0] acc_r [3];
  logic [31:0] d_r   [3];
  logic [31:0] mass_r, root_r, f_r;
  logic [63:0] sum_r, mg_r, plo_r, phi_r, den_r;
  logic        out_valid_r;
  logic [191:0] out_data_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  gsb_rd_ctl_t rd_ctl;
  gsb_rd_sts_t rd_sts;
  logic [31:0] rd_res;
  logic [63:0] rd_rem, rd_sh;

  logic        accept;
  logic [31:0] d_in [3];
  logic [63:0] r2, rad;
  logic [96:0] r3_full, r3_shr;
  logic [63:0] r3, den_c;
  logic [64:0] den_sum;
  logic        f_sat;
  logic [31:0] d_sel, acc_sel, vel_sel;
  logic signed [32:0] d_abs;

  // saturate a wide signed value to the word range
  function automatic logic [31:0] sat_w(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // word + floor(p >> FRAC_BITS), the step clamped first when asked, sum saturated
  function automatic logic [31:0] upd(input logic [31:0] old, input logic signed [65:0] p,
                                      input logic clamp);
    logic signed [65:0] t;
    logic [31:0]        ts;
    logic signed [65:0] s;
    t  = p >>> FRAC_BITS;
    ts = sat_w(t);
    s  = 66'(signed'(old)) + (clamp ? 66'(signed'(ts)) : t);
    return sat_w(s);
  endfunction

  gsb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  gsb_rootdiv u_rd (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rd_ctl),
    .init_rem (rd_rem),
    .init_sh  (rd_sh),
    .divisor  (den_r),
    .sts      (rd_sts),
    .result   (rd_res)
  );

  assign accept = in_tvalid && in_tready;

  // distance to the other body, saturated
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_in[i] = sat_w(66'(signed'(in_tdata[32*i +: 32])) - 66'(signed'(pos_r[i])));
    end
  end

  // per-axis selection for the multiplier passes
  always_comb begin
    case (cnt_r)
      2'd0:    begin d_sel = d_r[0]; acc_sel = acc_r[0]; vel_sel = vel_r[0]; end
      2'd1:    begin d_sel = d_r[1]; acc_sel = acc_r[1]; vel_sel = vel_r[1]; end
      default: begin d_sel = d_r[2]; acc_sel = acc_r[2]; vel_sel = vel_r[2]; end
    endcase
    prev  = cnt_r - 2'd1;
    d_abs = d_sel[31] ? -33'(signed'(d_sel)) : 33'(signed'(d_sel));
  end

  // radicand, r2 * root, denominator
  always_comb begin
    r2      = sum_r >> FRAC_BITS;
    rad     = (r2 + {32'b0, soft_r}) << FRAC_BITS;
    r3_full = {1'b0, phi_r, 32'b0} + {33'b0, plo_r};
    r3_shr  = r3_full >> FRAC_BITS;
    r3      = (|r3_shr[96:64]) ? {64{1'b1}} : r3_shr[63:0];
    den_sum = {1'b0, r3} + {33'b0, bias_r};
    den_c   = den_sum[64] ? {64{1'b1}} : den_sum[63:0];
    if (den_c == 64'd0) den_c = 64'd1;
    f_sat   = {32'b0, mg_r[63:32]} >= den_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            OP_ACCUM: state_nxt = S_SQ;
            OP_INTEG: state_nxt = S_VEL;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_SQ:        if (cnt_r == 2'd3) state_nxt = S_ROOT_GO;
      S_ROOT_GO:   state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: if (rd_sts.done) state_nxt = S_R3;
      S_R3:        if (cnt_r == 2'd2) state_nxt = S_DEN;
      S_DEN:       state_nxt = S_DIV_GO;
      S_DIV_GO:    state_nxt = f_sat ? S_ACC : S_DIV_WAIT;
      S_DIV_WAIT:  if (rd_sts.done) state_nxt = S_ACC;
      S_ACC:       if (cnt_r == 2'd3) state_nxt = S_DONE;
      S_VEL:       if (cnt_r == 2'd3) state_nxt = S_POS;
      S_POS:       if (cnt_r == 2'd3) state_nxt = S_DONE;
      S_DONE:      if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
    cnt_nxt = (state_nxt != state_r) ? 2'd0 : cnt_r + 2'd1;
  end

  // outputs of the sequencer: handshake, multiplier operands, unit start
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    mul_a         = '0;
    mul_b         = '0;
    rd_ctl.start  = 1'b0;
    rd_ctl.is_div = 1'b0;
    rd_rem        = '0;
    rd_sh         = rad;
    case (state_r)
      S_SQ: begin
        mul_a = d_abs;
        mul_b = d_abs;
      end
      S_ROOT_GO, S_ROOT_WAIT: begin
        mul_a = {1'b0, mass_r};
        mul_b = {1'b0, grav_r};
        rd_ctl.start = (state_r == S_ROOT_GO);
      end
      S_R3: begin
        mul_a = (cnt_r == 2'd0) ? {1'b0, r2[31:0]} : {1'b0, r2[63:32]};
        mul_b = {1'b0, root_r};
      end
      S_DIV_GO: begin
        rd_ctl.start  = ~f_sat;
        rd_ctl.is_div = 1'b1;
        rd_rem        = {32'b0, mg_r[63:32]};
        rd_sh         = {mg_r[31:0], 32'b0};
      end
      S_ACC: begin
        mul_a = 33'(signed'(d_sel));
        mul_b = {1'b0, f_r};
      end
      S_VEL: begin
        mul_a = 33'(signed'(acc_sel));
        mul_b = {1'b0, step_r};
      end
      S_POS: begin
        mul_a = 33'(signed'(vel_sel));
        mul_b = {1'b0, step_r};
      end
      default: ;
    endcase
  end

  // control registers and body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      grav_r      <= GRAV64[31:0];
      step_r      <= STEP64[31:0];
      soft_r      <= SOFT64[31:0];
      bias_r      <= STEP64[31:0];
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;

      // take register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_GRAV: grav_r <= cfg_data;
          REG_STEP: step_r <= cfg_data;
          REG_SOFT: soft_r <= cfg_data;
          REG_BIAS: bias_r <= cfg_data;
          default: ;
        endcase
      end

      // present a new result at the end of an item, drop one once taken
      if (state_r == S_DONE && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      // load and clear act at acceptance
      if (accept && in_tuser == OP_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          pos_r[i] <= in_tdata[32*i +: 32];
          vel_r[i] <= in_tdata[96 + 32*i +: 32];
          acc_r[i] <= '0;
        end
      end
      if (accept && in_tuser == OP_CLEAR) begin
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      end

      // write back one axis per cycle from the multiplier
      if (cnt_r != 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          if (prev == 2'(i)) begin
            if (state_r == S_ACC) acc_r[i] <= upd(acc_r[i], prod, 1'b1);
            if (state_r == S_VEL) vel_r[i] <= upd(vel_r[i], prod, 1'b0);
            if (state_r == S_POS) pos_r[i] <= upd(pos_r[i], prod, 1'b0);
          end
        end
      end
    end
  end

  // working payload of an accumulate
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) d_r[i] <= d_in[i];
      mass_r <= in_tdata[223:192];
    end
    case (state_r)
      S_SQ:        sum_r <= (cnt_r == 2'd0) ? 64'd0 : sum_r + prod[63:0];
      S_ROOT_WAIT: begin
        mg_r <= prod[63:0];
        if (rd_sts.done) root_r <= rd_res;
      end
      S_R3: begin
        if (cnt_r == 2'd1) plo_r <= prod[63:0];
        if (cnt_r == 2'd2) phi_r <= prod[63:0];
      end
      S_DEN:       den_r <= den_c;
      S_DIV_GO:    if (f_sat) f_r <= 32'hffff_ffff;
      S_DIV_WAIT:  if (rd_sts.done) f_r <= rd_res;
      default: ;
    endcase
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {vel_r[2], vel_r[1], vel_r[0], pos_r[2], pos_r[1], pos_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/gsb_checker.sv]
// Port-level checks of the integrator and their binding to the top level.
module gsb_checker import gsb_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [223:0] in_tdata,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic         cfg_we,
  input logic [1:0]   cfg_index,
  input logic [31:0]  cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a result leaves only when taken
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("result dropped without handshake");

  // the block is busy after taking a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a load shows the loaded x position and x velocity, via the done state and the output register
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_LOAD && (!out_tvalid || out_tready)
    |-> ##2 out_tvalid && out_tdata[31:0] == $past(in_tdata[31:0], 2)
        && out_tdata[127:96] == $past(in_tdata[127:96], 2))
    else $error("load result mismatch");

endmodule

bind softened_gravity_body_integrator gsb_checker u_gsb_checker (.*);

[tb/sv/tb.sv]
// Testbench for the softened-gravity body integrator: directed and random requests, checked against a built-in predictor.
`timescale 1ns / 100ps

module tb;
  import gsb_pkg::*;

  localparam int FRAC = 16;

  typedef struct packed {
    logic [31:0] mass;
    logic [31:0] vz, vy, vx;
    logic [31:0] z, y, x;
  } body_req_t;

  typedef struct {
    gsb_op_t   op;
    body_req_t data;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  softened_gravity_body_integrator i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and register copies
  longint pos_q[3], vel_q[3], acc_q[3];
  longint unsigned grav_r, step_r, soft_r, bias_r;
  logic [191:0] expected_state[$];
  item_t pending[$];
  int errors = 0;
  bit quiet_tail = 0;
  bit hold_off = 0;

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_floor(longint a, longint unsigned b);
    longint p;
    p = a * longint'(b);
    return p >>> FRAC;
  endfunction

  function automatic longint unsigned int_root(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void predict_body(item_t it);
    longint d[3];
    longint unsigned sum, r2, root, r3, den, f, hi, lo;
    logic [127:0] mg;
    logic [31:0] px[3];
    logic [191:0] res;
    px[0] = it.data.x; px[1] = it.data.y; px[2] = it.data.z;
    case (it.op)
      OP_LOAD: begin
        pos_q[0] = longint'($signed(it.data.x));
        pos_q[1] = longint'($signed(it.data.y));
        pos_q[2] = longint'($signed(it.data.z));
        vel_q[0] = longint'($signed(it.data.vx));
        vel_q[1] = longint'($signed(it.data.vy));
        vel_q[2] = longint'($signed(it.data.vz));
        foreach (acc_q[i]) acc_q[i] = 0;
      end
      OP_ACCUM: begin
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = sat_word(longint'($signed(px[i])) - pos_q[i]);
          sum += longint'(d[i] < 0 ? -d[i] : d[i]) * longint'(d[i] < 0 ? -d[i] : d[i]);
        end
        r2 = sum >> FRAC;
        root = int_root((r2 + soft_r) << FRAC);
        hi = r2 >> FRAC;
        lo = ((r2 & 64'hFFFF) * root) >> FRAC;
        if (root != 0 && hi > (64'hFFFF_FFFF_FFFF_FFFF - lo) / root) r3 = '1;
        else r3 = hi * root + lo;
        den = (r3 > 64'hFFFF_FFFF_FFFF_FFFF - bias_r) ? '1 : r3 + bias_r;
        if (den == 0) den = 1;
        mg = 128'(it.data.mass) * 128'(grav_r);
        mg = mg / 128'(den);
        f = (mg > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : mg[63:0];
        for (int i = 0; i < 3; i++)
          acc_q[i] = sat_word(acc_q[i] + sat_word(scale_floor(d[i], f)));
      end
      OP_INTEG: begin
        for (int i = 0; i < 3; i++)
          vel_q[i] = sat_word(vel_q[i] + scale_floor(acc_q[i], step_r));
        for (int i = 0; i < 3; i++)
          pos_q[i] = sat_word(pos_q[i] + scale_floor(vel_q[i], step_r));
      end
      default: foreach (acc_q[i]) acc_q[i] = 0;
    endcase
    for (int i = 0; i < 3; i++) begin
      res[32*i +: 32] = pos_q[i][31:0];
      res[32*(i+3) +: 32] = vel_q[i][31:0];
    end
    expected_state.push_back(res);
  endfunction

  // Driver: take the next pending request, idle in random bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        item_t acc_it;
        acc_it.op = gsb_op_t'(in_tuser);
        acc_it.data = in_tdata;
        predict_body(acc_it);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          item_t nx;
          nx = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nx.op;
          in_tdata <= nx.data;
          if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_state.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          errors++;
        end else begin
          logic [191:0] exp_v;
          exp_v = expected_state.pop_front();
          for (int i = 0; i < 6; i++)
            if (exp_v[32*i +: 32] !== out_tdata[32*i +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, i,
                       exp_v[32*i +: 32], out_tdata[32*i +: 32]);
              errors++;
            end
        end
      end
      if (hold_off) out_tready <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 6) == 0) recv_gap <= $urandom_range(1, 17);
      end
    end
  end

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Small-magnitude Q16.16 word, most pulls stay in range
  function automatic logic [31:0] near_word();
    return $urandom_range(0, 3) == 0 ? edge_word()
                                     : 32'($signed($urandom_range(0, 2000000)) - 1000000);
  endfunction

  function automatic void queue_req(gsb_op_t op, body_req_t d);
    item_t it;
    it.op = op;
    it.data = d;
    pending.push_back(it);
  endfunction

  function automatic void queue_random(int n);
    body_req_t d;
    gsb_op_t op;
    for (int k = 0; k < n; k++) begin
      d = {near_word(), near_word(), near_word(), near_word(),
           near_word(), near_word(), near_word()};
      d.mass = $urandom_range(0, 3) == 0 ? edge_word() : $urandom_range(0, 1 << 20);
      case ($urandom_range(0, 9))
        0: op = OP_LOAD;
        1: op = OP_CLEAR;
        2, 3, 4: op = OP_INTEG;
        default: op = OP_ACCUM;
      endcase
      queue_req(op, d);
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRAV: grav_r = val;
      REG_STEP: step_r = val;
      REG_SOFT: soft_r = val;
      default:  bias_r = val;
    endcase
  endtask

  // Wait mid-cycle so that the edge's updates have all settled
  task automatic drain();
    while (pending.size() > 0 || in_tvalid || expected_state.size() > 0) @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    body_req_t d;
    grav_r = 65536; step_r = 655; soft_r = 4096; bias_r = 655;
    foreach (pos_q[i]) begin pos_q[i] = 0; vel_q[i] = 0; acc_q[i] = 0; end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every operation, word extremes, coincident bodies
    d = '0;
    queue_req(OP_ACCUM, d);
    queue_req(OP_INTEG, d);
    d = {32'hFFFF_FFFF, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
    queue_req(OP_LOAD, d);
    queue_req(OP_ACCUM, {32'hFFFF_FFFF, {3{32'h0}}, {3{32'h7FFF_FFFF}}});
    queue_req(OP_INTEG, d);
    queue_req(OP_INTEG, d);
    queue_req(OP_CLEAR, d);
    queue_req(OP_LOAD, {32'h0, {3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
    queue_req(OP_ACCUM, {32'h0001_0000, {3{32'h0}}, {3{32'h8000_0000}}});
    queue_req(OP_INTEG, d);
    queue_req(OP_LOAD, {32'h0, {3{32'h0001_0000}}, 32'h0, 32'h0, 32'h0});
    queue_req(OP_ACCUM, {32'h0010_0000, 96'h0, 32'h0, 32'h0, 32'h0002_0000});
    queue_req(OP_INTEG, d);
    drain();

    // Zero bias and zero softening: coincident body divides by one
    write_reg(REG_BIAS, 32'h0);
    write_reg(REG_SOFT, 32'h0);
    queue_req(OP_LOAD, '0);
    queue_req(OP_ACCUM, {32'hFFFF_FFFF, 192'h0});
    queue_req(OP_ACCUM, {32'h0001_0000, 96'h0, 32'h0, 32'h0, 32'h0000_0001});
    queue_req(OP_INTEG, '0);
    queue_random(150);
    drain();

    // Extreme register settings
    write_reg(REG_GRAV, 32'hFFFF_FFFF);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_SOFT, 32'hFFFF_FFFF);
    write_reg(REG_BIAS, 32'hFFFF_FFFF);
    queue_random(150);
    drain();
    write_reg(REG_GRAV, 32'h0);
    write_reg(REG_STEP, 32'h0);
    write_reg(REG_BIAS, 32'h1);
    queue_random(100);
    drain();

    // Random settings; long receiver hold-off fills the block
    write_reg(REG_GRAV, $urandom());
    write_reg(REG_STEP, $urandom_range(0, 1 << 18));
    write_reg(REG_SOFT, $urandom());
    write_reg(REG_BIAS, $urandom() | 32'h1);
    hold_off = 1;
    queue_random(200);
    repeat (600) @(posedge clk);
    hold_off = 0;
    drain();

    // Defaults, no idling in the tail
    write_reg(REG_GRAV, 32'd65536);
    write_reg(REG_STEP, 32'd655);
    write_reg(REG_SOFT, 32'd4096);
    write_reg(REG_BIAS, 32'd655);
    quiet_tail = 1;
    queue_random(230);
    drain();

    if (errors == 0) $display("[softened_gravity_body_integrator] OK");
    else $display("[softened_gravity_body_integrator] ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[softened_gravity_body_integrator] ERROR");
    $finish;
  end

endmodule
